/* rtl/core/clcd_pkg.sv */
`timescale 1ns / 1ps

package clcd_pkg;

  localparam logic [5:0] POWER_ON_TICKS = 6'd20;
  localparam logic [5:0] SETTLE_TICKS   = 6'd2;
  localparam logic [5:0] FINAL_WAIT     = 6'd5;
  localparam logic [3:0] STEP_DONE      = 4'd10;
  localparam logic [7:0] CLEAR_WORD     = 8'h01;

  localparam logic [7:0] FUNCTION_SET_RESET    = 8'h28;
  localparam logic [7:0] DISPLAY_CONTROL_RESET = 8'h0C;
  localparam logic [7:0] ENTRY_MODE_RESET      = 8'h06;

  localparam logic [1:0] REG_FUNCTION_SET    = 2'd0;
  localparam logic [1:0] REG_DISPLAY_CONTROL = 2'd1;
  localparam logic [1:0] REG_ENTRY_MODE      = 2'd2;

  // init steps
  localparam logic [3:0] STEP_WAKE_FIRST = 4'd1;
  localparam logic [3:0] STEP_WAKE_LAST  = 4'd4;
  localparam logic [3:0] STEP_FUNC_SET   = 4'd5;
  localparam logic [3:0] STEP_DISP_CTRL  = 4'd6;
  localparam logic [3:0] STEP_ENTRY_MODE = 4'd7;
  localparam logic [3:0] STEP_CLEAR      = 4'd8;
  localparam logic [3:0] STEP_FINAL_WAIT = 4'd9;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_WAIT   = 3'd1,
    PH_HI_EN  = 3'd2,
    PH_HI_LOW = 3'd3,
    PH_LO_EN  = 3'd4,
    PH_LO_LOW = 3'd5
  } phase_t;

  // one classified tick between front and back
  typedef struct packed {
    logic       req;
    logic       is_data;
    logic [7:0] write_byte;
  } tick_t;

  typedef struct packed {
    logic       pin_rs;
    logic       pin_enable;
    logic [3:0] pin_nibble;
    logic       ready_res;
    logic       request_taken;
  } result_t;

  function automatic logic [3:0] wake_nibble(input logic [1:0] idx);
    logic [3:0] n;
    unique case (idx)
      2'd3:    n = 4'h2;
      default: n = 4'h3;
    endcase
    return n;
  endfunction

  function automatic logic [5:0] wake_wait(input logic [1:0] idx);
    logic [5:0] w;
    unique case (idx)
      2'd0:    w = 6'd5;
      2'd1:    w = 6'd1;
      2'd2:    w = 6'd1;
      default: w = 6'd0;
    endcase
    return w;
  endfunction

endpackage

/* rtl/core/clcd_tick_fifo.sv */
`timescale 1ns / 1ps

module clcd_tick_fifo
  import clcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // write_byte
  input  logic [1:0] s_tuser,   // req_type, is_data
  output logic       q_valid,
  input  logic       q_pop,
  output tick_t      q_tick
);

  tick_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  tick_t      in_tick;

  always_comb begin
    in_tick.req        = s_tuser[0];
    in_tick.is_data    = s_tuser[1];
    in_tick.write_byte = s_tdata;
  end

  assign s_tready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign push     = s_tvalid && s_tready;
  assign pop      = q_pop && q_valid;
  assign q_tick   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_tick;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

endmodule

/* rtl/core/clcd_seq.sv */
`timescale 1ns / 1ps

module clcd_seq
  import clcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       q_valid,
  output logic       q_pop,
  input  tick_t      q_tick,
  output logic       m_tvalid,
  input  logic       m_tready,
  output result_t    m_res
);

  logic [7:0] function_set_word;
  logic [7:0] display_control_word;
  logic [7:0] entry_mode_word;

  logic [3:0] init_step, init_step_next;
  phase_t     phase, phase_next;
  logic [5:0] wait_count, wait_count_next;
  logic [7:0] held_byte, held_byte_next;
  logic       held_rs, held_rs_next;
  logic [3:0] nibble_levels, nibble_levels_next;
  result_t    res_next;
  logic       ready;
  logic       taken;
  logic       do_finish;
  logic       do_start;
  logic [5:0] w;

  assign q_pop = q_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      function_set_word    <= FUNCTION_SET_RESET;
      display_control_word <= DISPLAY_CONTROL_RESET;
      entry_mode_word      <= ENTRY_MODE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FUNCTION_SET:    function_set_word    <= cfg_data;
        REG_DISPLAY_CONTROL: display_control_word <= cfg_data;
        REG_ENTRY_MODE:      entry_mode_word      <= cfg_data;
        default: ;
      endcase
    end
  end

  // one tick of the bus sequencer
  always_comb begin
    init_step_next     = init_step;
    phase_next         = phase;
    wait_count_next    = wait_count;
    held_byte_next     = held_byte;
    held_rs_next       = held_rs;
    nibble_levels_next = nibble_levels;
    do_finish          = 1'b0;
    do_start           = 1'b0;
    w                  = 6'd0;

    ready = (init_step >= STEP_DONE) && (phase == PH_IDLE);
    taken = q_tick.req && ready;

    if (taken) begin
      held_byte_next     = q_tick.write_byte;
      held_rs_next       = q_tick.is_data;
      nibble_levels_next = q_tick.write_byte[7:4];
      phase_next         = PH_HI_EN;
    end

    res_next.pin_rs        = held_rs_next;
    res_next.pin_enable    = (phase_next == PH_HI_EN) || (phase_next == PH_LO_EN);
    res_next.pin_nibble    = nibble_levels_next;
    res_next.ready_res     = ready;
    res_next.request_taken = taken;

    unique case (phase_next)
      PH_WAIT: begin
        if (wait_count <= 6'd1) do_finish = 1'b1;
        else wait_count_next = wait_count - 6'd1;
      end
      PH_HI_EN: phase_next = PH_HI_LOW;
      PH_HI_LOW: begin
        nibble_levels_next = held_byte_next[3:0];
        phase_next         = PH_LO_EN;
      end
      PH_LO_EN: phase_next = PH_LO_LOW;
      PH_LO_LOW: begin
        if (init_step >= STEP_WAKE_FIRST && init_step <= STEP_WAKE_LAST) begin
          w = wake_wait(2'(init_step - STEP_WAKE_FIRST));
          if (w == 6'd0) begin
            do_finish = 1'b1;
          end else begin
            phase_next      = PH_WAIT;
            wait_count_next = w;
          end
        end else begin
          phase_next      = PH_WAIT;
          wait_count_next = SETTLE_TICKS;
        end
      end
      default: begin
        if (init_step < STEP_DONE) do_start = 1'b1;
        else phase_next = PH_IDLE;
      end
    endcase

    if (do_finish) begin
      if (init_step < STEP_DONE) begin
        init_step_next = init_step + 4'd1;
        do_start       = 1'b1;
      end else begin
        phase_next = PH_IDLE;
      end
    end

    if (do_start) begin
      priority if (init_step_next >= STEP_WAKE_FIRST && init_step_next <= STEP_WAKE_LAST) begin
        held_rs_next       = 1'b0;
        nibble_levels_next = wake_nibble(2'(init_step_next - STEP_WAKE_FIRST));
        held_byte_next     = {4'h0, nibble_levels_next};
        phase_next         = PH_LO_EN;
      end else if (init_step_next >= STEP_FUNC_SET && init_step_next <= STEP_CLEAR) begin
        unique case (init_step_next)
          STEP_FUNC_SET:   held_byte_next = function_set_word;
          STEP_DISP_CTRL:  held_byte_next = display_control_word;
          STEP_ENTRY_MODE: held_byte_next = entry_mode_word;
          default:         held_byte_next = CLEAR_WORD;
        endcase
        held_rs_next       = 1'b0;
        nibble_levels_next = held_byte_next[7:4];
        phase_next         = PH_HI_EN;
      end else if (init_step_next == STEP_FINAL_WAIT) begin
        phase_next      = PH_WAIT;
        wait_count_next = FINAL_WAIT;
      end else begin
        phase_next = PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_step     <= 4'd0;
      phase         <= PH_WAIT;
      wait_count    <= POWER_ON_TICKS;
      held_byte     <= 8'h00;
      held_rs       <= 1'b0;
      nibble_levels <= 4'h0;
    end else if (q_pop) begin
      init_step     <= init_step_next;
      phase         <= phase_next;
      wait_count    <= wait_count_next;
      held_byte     <= held_byte_next;
      held_rs       <= held_rs_next;
      nibble_levels <= nibble_levels_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (q_pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) m_res <= res_next;
  end

  a_idle_after_init: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> init_step >= STEP_DONE)
    else $error("bus idle before init done");

  a_wait_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_WAIT |-> wait_count != 6'd0)
    else $error("wait with zero count");

  a_taken_ready: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_res.request_taken |-> m_res.ready_res && m_res.pin_enable)
    else $error("request taken while not ready");

  a_taken_phase: assert property (@(posedge clk) disable iff (rst)
    q_pop && taken |=> phase == PH_HI_LOW)
    else $error("taken request did not start high nibble");

endmodule

/* rtl/core/char_lcd_4bit_write_sequencer.sv */
`timescale 1ns / 1ps
// A tick's result is registered first in the tick queue and then in the
// sequencer's output register.
// Throughput: one tick per cycle while m_tready is high; m_tready low holds the sequencer and backs up the tick queue.
// Reset: synchronous; the power-on sequence then runs on the incoming ticks, taking POWER_ON_TICKS,
// the wake-up and init bytes with their settle waits, and FINAL_WAIT before ready_res rises.

module char_lcd_4bit_write_sequencer
  import clcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // write_byte
  input  logic [1:0] s_tuser,   // req_type, is_data
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // pin_rs, pin_enable, pin_nibble[3:0], 2'b0
  output logic [1:0] m_tuser    // ready_res, request_taken
);

  logic    q_valid;
  logic    q_pop;
  tick_t   q_tick;
  result_t res;

  clcd_tick_fifo u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_tick   (q_tick)
  );

  clcd_seq u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_tick    (q_tick),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_res     (res)
  );

  assign m_tdata = {2'b00, res.pin_nibble, res.pin_enable, res.pin_rs};
  assign m_tuser = {res.request_taken, res.ready_res};

endmodule
